/* sv/kfl_pkg.sv */
`default_nettype none
package kfl_pkg;

   localparam int MAX_KEYS    = 64;
   localparam int IDX_W       = $clog2(MAX_KEYS);
   localparam int CNT_W       = $clog2(MAX_KEYS + 1);
   localparam int KEY_COUNT_W = 7;
   localparam int TIME_W      = 32;
   localparam int VAL_W       = 32;
   localparam int FRAC_W      = 16;
   localparam int SLOT_W      = 6;
   localparam int SEG_W       = 6;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic                     command;
      logic [SLOT_W-1:0]        key_slot;
      logic [TIME_W-1:0]        time_req;
      logic signed [VAL_W-1:0]  value_x;
      logic signed [VAL_W-1:0]  value_y;
      logic signed [VAL_W-1:0]  value_z;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  out_x;
      logic signed [VAL_W-1:0]  out_y;
      logic signed [VAL_W-1:0]  out_z;
      logic [SEG_W-1:0]         segment;
      logic                     past_end;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/kfl_key_mem.sv */
`default_nettype none
// Key storage: a time memory and a vector memory, one write port shared,
// one registered read port each.
module kfl_key_mem (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [kfl_pkg::IDX_W-1:0] wr_addr,
   input  wire logic [kfl_pkg::TIME_W-1:0] wr_time,
   input  wire kfl_pkg::vec_type          wr_vec,
   input  wire logic                      time_rd_en,
   input  wire logic [kfl_pkg::IDX_W-1:0] time_rd_addr,
   output logic [kfl_pkg::TIME_W-1:0]     time_rd_data,
   input  wire logic                      vec_rd_en,
   input  wire logic [kfl_pkg::IDX_W-1:0] vec_rd_addr,
   output kfl_pkg::vec_type               vec_rd_data
);
   import kfl_pkg::*;

   logic [TIME_W-1:0] time_mem [MAX_KEYS];
   vec_type           vec_mem  [MAX_KEYS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         vec_mem[wr_addr]  <= wr_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (time_rd_en) begin
         time_rd_data <= time_mem[time_rd_addr];
      end
      if (vec_rd_en) begin
         vec_rd_data <= vec_mem[vec_rd_addr];
      end
   end

endmodule
`default_nettype wire

/* sv/kfl_div.sv */
`default_nettype none
// Restoring divider: one quotient bit per cycle, FRAC_W quotient bits.
// The numerator is below the denominator, so the quotient fits FRAC_W bits.
module kfl_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [kfl_pkg::TIME_W-1:0] num,
   input  wire logic [kfl_pkg::TIME_W-1:0] den,
   output logic                            done,
   output logic [kfl_pkg::FRAC_W-1:0]      quo
);
   import kfl_pkg::*;

   localparam int STEP_W = $clog2(FRAC_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [TIME_W-1:0]   den_ff, den_in;
   logic [FRAC_W-1:0]   quo_ff, quo_in;
   logic [TIME_W:0]     rem_dbl;
   logic [TIME_W:0]     rem_sub;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem_dbl = {rem_ff, 1'b0};
      rem_sub = rem_dbl - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (rem_dbl >= {1'b0, den_ff}) begin
            rem_in = rem_sub[TIME_W-1:0];
            quo_in = {quo_ff[FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = rem_dbl[TIME_W-1:0];
            quo_in = {quo_ff[FRAC_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

/* sv/kfl_lerp.sv */
`default_nettype none
// Three-lane blend: difference, product with the fraction, then the sum.
// The product's low FRAC_W bits are dropped, which floors towards minus infinity.
module kfl_lerp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire kfl_pkg::vec_type           vec_a,
   input  wire kfl_pkg::vec_type           vec_b,
   input  wire logic [kfl_pkg::FRAC_W-1:0] frac,
   output logic                            done,
   output kfl_pkg::vec_type                res
);
   import kfl_pkg::*;

   localparam int DIFF_W = VAL_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [VAL_W-1:0]  a_lane   [3];
   logic signed [VAL_W-1:0]  b_lane   [3];
   logic signed [VAL_W-1:0]  a1_ff    [3];
   logic signed [VAL_W-1:0]  a2_ff    [3];
   logic signed [DIFF_W-1:0] diff_ff  [3];
   logic [FRAC_W-1:0]        frac_ff;
   logic [VAL_W-1:0]         prod_ff  [3];
   logic [VAL_W-1:0]         sum_ff   [3];
   logic signed [PROD_W-1:0] prod_full [3];

   assign a_lane[0] = vec_a.x;
   assign a_lane[1] = vec_a.y;
   assign a_lane[2] = vec_a.z;
   assign b_lane[0] = vec_b.x;
   assign b_lane[1] = vec_b.y;
   assign b_lane[2] = vec_b.z;

   for (genvar c = 0; c < 3; c++) begin : g_lane
      assign prod_full[c] = diff_ff[c] * $signed({1'b0, frac_ff});

      always_ff @(posedge clock) begin
         if (start) begin
            diff_ff[c] <= DIFF_W'(b_lane[c]) - DIFF_W'(a_lane[c]);
            a1_ff[c]   <= a_lane[c];
         end
         prod_ff[c] <= prod_full[c][FRAC_W +: VAL_W];
         a2_ff[c]   <= a1_ff[c];
         sum_ff[c]  <= a2_ff[c] + prod_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         frac_ff <= frac;
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign done  = v3_ff;
   assign res.x = sum_ff[0];
   assign res.y = sum_ff[1];
   assign res.z = sum_ff[2];

endmodule
`default_nettype wire

/* sv/keyframe_track_lerp_unit.sv */
`default_nettype none
// Channel  | Direction | Handshake         | Payload
// req      | in        | req_valid/stall   | kfl_pkg::req_type (load or sample)
// rsp      | out       | rsp_valid/stall   | kfl_pkg::rsp_type (one per sample)
// csr      | in        | csr_wr_en         | key_count, 7 bits
//
// A load is written into memory at the transfer edge.
// A sample first runs the key time search, which reads one time per cycle
// from the time memory; when it interpolates, the divider runs while both
// key vectors are fetched, followed by the 3-stage blend.
// Reset is synchronous and sets key_count to one; key memories are not cleared.
// A finished result sits in the output register; a new request transfer is
// taken while it waits, and the next result waits in its final state.
module keyframe_track_lerp_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire kfl_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output kfl_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [kfl_pkg::KEY_COUNT_W-1:0] csr_wr_data
);
   import kfl_pkg::*;

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_KEY    = 4'd2;
   localparam logic [3:0] S_KEYCAP = 4'd3;
   localparam logic [3:0] S_VLO    = 4'd4;
   localparam logic [3:0] S_VHI    = 4'd5;
   localparam logic [3:0] S_VCAP   = 4'd6;
   localparam logic [3:0] S_DIVW   = 4'd7;
   localparam logic [3:0] S_BLEND  = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [KEY_COUNT_W-1:0] key_count_ff;
   logic [IDX_W-1:0]       n_last;
   logic [TIME_W-1:0]      t_ff, t_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [TIME_W-1:0]      prev_time_ff, prev_time_in;
   logic [IDX_W-1:0]       seg_ff, seg_in;
   logic                   past_ff, past_in;
   vec_type                vec_a_ff, vec_a_in;
   vec_type                vec_b_ff, vec_b_in;
   vec_type                res_vec_ff, res_vec_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   req_xfer;
   logic                   mem_wr;
   logic                   time_rd_en;
   logic [IDX_W-1:0]       time_rd_addr;
   logic [TIME_W-1:0]      time_rd_data;
   logic                   vec_rd_en;
   logic [IDX_W-1:0]       vec_rd_addr;
   vec_type                vec_rd_data;
   vec_type                wr_vec;

   logic                   div_start;
   logic [TIME_W-1:0]      div_num, div_den;
   logic                   div_done;
   logic [FRAC_W-1:0]      div_quo;
   logic                   blend_start;
   logic                   blend_done;
   vec_type                blend_res;

   // Effective key count, held to the range one to MAX_KEYS, as a last index.
   always_comb begin
      if (key_count_ff == '0) begin
         n_last = '0;
      end else if (key_count_ff > KEY_COUNT_W'(MAX_KEYS)) begin
         n_last = IDX_W'(MAX_KEYS - 1);
      end else begin
         n_last = IDX_W'(key_count_ff - 1'b1);
      end
   end

   // Requests are only taken in the idle state, and memory reads only happen
   // outside it, so a load can never collide with a read of the same entry.
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign mem_wr    = req_xfer && (req_data.command == CMD_LOAD);
   assign wr_vec.x  = req_data.value_x;
   assign wr_vec.y  = req_data.value_y;
   assign wr_vec.z  = req_data.value_z;

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      prev_time_in = prev_time_ff;
      seg_in       = seg_ff;
      past_in      = past_ff;
      vec_a_in     = vec_a_ff;
      vec_b_in     = vec_b_ff;
      res_vec_in   = res_vec_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      time_rd_en   = 1'b0;
      time_rd_addr = issue_ff[IDX_W-1:0];
      vec_rd_en    = 1'b0;
      vec_rd_addr  = seg_ff;
      div_start    = 1'b0;
      div_num      = t_ff - prev_time_ff;
      div_den      = time_rd_data - prev_time_ff;
      blend_start  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_data.command == CMD_SAMPLE) begin
               t_in     = req_data.time_req;
               past_in  = 1'b0;
               issue_in = '0;
               if (n_last == '0) begin
                  // Single key: key 0 straight back.
                  seg_in   = '0;
                  state_in = S_KEY;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            // Times are issued one per cycle; each is compared in the next cycle,
            // together with the previous time, which is the lower key.
            if (issue_ff <= CNT_W'(n_last)) begin
               time_rd_en = 1'b1;
               issue_in   = issue_ff + 1'b1;
               rd_vld_in  = 1'b1;
               rd_idx_in  = issue_ff[IDX_W-1:0];
            end
            if (rd_vld_ff) begin
               prev_time_in = time_rd_data;
               if (rd_idx_ff != '0) begin
                  if (t_ff < time_rd_data) begin
                     seg_in    = rd_idx_ff - 1'b1;
                     rd_vld_in = 1'b0;
                     if (t_ff <= prev_time_ff) begin
                        // At or before the lower key, zero-length segment
                        // included: the lower key is returned as it stands.
                        state_in = S_KEY;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_VLO;
                     end
                  end else if (rd_idx_ff == n_last) begin
                     // No later key: the last key is returned and flagged.
                     seg_in    = n_last;
                     past_in   = 1'b1;
                     rd_vld_in = 1'b0;
                     state_in  = S_KEY;
                  end
               end
            end
         end

         S_KEY: begin
            vec_rd_en = 1'b1;
            state_in  = S_KEYCAP;
         end

         S_KEYCAP: begin
            res_vec_in = vec_rd_data;
            state_in   = S_OUT;
         end

         S_VLO: begin
            vec_rd_en = 1'b1;
            state_in  = S_VHI;
         end

         S_VHI: begin
            vec_rd_en   = 1'b1;
            vec_rd_addr = seg_ff + 1'b1;
            vec_a_in    = vec_rd_data;
            state_in    = S_VCAP;
         end

         S_VCAP: begin
            vec_b_in = vec_rd_data;
            state_in = S_DIVW;
         end

         S_DIVW: begin
            if (div_done) begin
               blend_start = 1'b1;
               state_in    = S_BLEND;
            end
         end

         S_BLEND: begin
            if (blend_done) begin
               res_vec_in = blend_res;
               state_in   = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.out_x    = res_vec_ff.x;
               rsp_in.out_y    = res_vec_ff.y;
               rsp_in.out_z    = res_vec_ff.z;
               rsp_in.segment  = SEG_W'(seg_ff);
               rsp_in.past_end = past_ff;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_count_ff <= KEY_COUNT_W'(1);
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            key_count_ff <= csr_wr_data;
         end
      end
      t_ff         <= t_in;
      issue_ff     <= issue_in;
      rd_idx_ff    <= rd_idx_in;
      prev_time_ff <= prev_time_in;
      seg_ff       <= seg_in;
      past_ff      <= past_in;
      vec_a_ff     <= vec_a_in;
      vec_b_ff     <= vec_b_in;
      res_vec_ff   <= res_vec_in;
      rsp_ff       <= rsp_in;
   end

   kfl_key_mem u_mem (
      .clock        (clock),
      .wr_en        (mem_wr),
      .wr_addr      (IDX_W'(req_data.key_slot)),
      .wr_time      (req_data.time_req),
      .wr_vec       (wr_vec),
      .time_rd_en   (time_rd_en),
      .time_rd_addr (time_rd_addr),
      .time_rd_data (time_rd_data),
      .vec_rd_en    (vec_rd_en),
      .vec_rd_addr  (vec_rd_addr),
      .vec_rd_data  (vec_rd_data)
   );

   kfl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   kfl_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .vec_a (vec_a_ff),
      .vec_b (vec_b_ff),
      .frac  (div_quo),
      .done  (blend_done),
      .res   (blend_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The divider must finish only once both key vectors have been fetched.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVW)
      else $error("divider finished outside its wait state");

   // The blend result must land while the sequencer is waiting for it.
   a_blend_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      blend_done |-> state_ff == S_BLEND)
      else $error("blend finished outside its wait state");

   // A started division leads straight into the vector fetch.
   a_div_start_fetch: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == S_VLO)
      else $error("division started without a vector fetch");

   // Leaving the output state always leaves a result on the response port.
   a_out_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && state_in == S_IDLE) |=> rsp_valid)
      else $error("result lost on leaving the output state");

endmodule
`default_nettype wire

/* dv/keyframe_track_lerp_checker.sv */
module keyframe_track_lerp_checker
   import kfl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire req_type                req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire rsp_type                rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [KEY_COUNT_W-1:0] csr_wr_data,
   output int unsigned                 mismatch_count,
   output int unsigned                 samples_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the track, written by every load transfer.
   logic [TIME_W-1:0]      key_time [MAX_KEYS];
   vec_type                key_vec  [MAX_KEYS];
   logic [KEY_COUNT_W-1:0] key_count_q;
   rsp_type                lerp_expect_q [$];

   // a + floor((b - a) * frac / 2^16); the arithmetic shift gives the floor.
   function automatic logic [VAL_W-1:0] lerp_component(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b,
                                                      input logic [FRAC_W-1:0] frac);
      longint span;
      longint prod;
      span = longint'(b) - longint'(a);
      prod = span * longint'(frac);
      return VAL_W'(longint'(a) + (prod >>> FRAC_W));
   endfunction

   function automatic rsp_type hold_key(input int unsigned k, input logic past);
      rsp_type r;
      r.out_x    = key_vec[k].x;
      r.out_y    = key_vec[k].y;
      r.out_z    = key_vec[k].z;
      r.segment  = SEG_W'(k);
      r.past_end = past;
      return r;
   endfunction

   function automatic rsp_type sample_track(input logic [TIME_W-1:0] t);
      int unsigned       n;
      int unsigned       seg;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
      logic [63:0]       num;
      logic [FRAC_W-1:0] frac;
      rsp_type           r;
      n = key_count_q;
      if (n == 0) n = 1;
      else if (n > MAX_KEYS) n = MAX_KEYS;
      if (n == 1) return hold_key(0, 1'b0);
      seg = 0;
      while (seg + 1 < n && t >= key_time[seg + 1]) seg++;
      if (seg + 1 == n) return hold_key(n - 1, 1'b1);
      lo = key_time[seg];
      hi = key_time[seg + 1];
      if (t <= lo) return hold_key(seg, 1'b0);
      num  = {32'h0, t - lo} << FRAC_W;
      frac = FRAC_W'(num / {32'h0, hi - lo});
      r.out_x    = lerp_component(key_vec[seg].x, key_vec[seg + 1].x, frac);
      r.out_y    = lerp_component(key_vec[seg].y, key_vec[seg + 1].y, frac);
      r.out_z    = lerp_component(key_vec[seg].z, key_vec[seg + 1].z, frac);
      r.segment  = SEG_W'(seg);
      r.past_end = 1'b0;
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %h, actual %h", label, want, seen);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      if (reset) begin
         key_count_q = 7'd1;
         lerp_expect_q.delete();
      end else begin
         if (csr_wr_en) key_count_q = csr_wr_data;
         if (req_valid && !req_stall) begin
            if (req_data.command == CMD_LOAD) begin
               key_time[req_data.key_slot] = req_data.time_req;
               key_vec[req_data.key_slot]  = {req_data.value_x, req_data.value_y,
                                              req_data.value_z};
            end else begin
               lerp_expect_q.push_back(sample_track(req_data.time_req));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (lerp_expect_q.size() == 0) begin
               $error("Response transfer arrived with no sample outstanding");
               mismatch_count++;
            end else begin
               want = lerp_expect_q.pop_front();
               check_field("out_x", want.out_x, rsp_data.out_x);
               check_field("out_y", want.out_y, rsp_data.out_y);
               check_field("out_z", want.out_z, rsp_data.out_z);
               check_field("segment", 32'(want.segment), 32'(rsp_data.segment));
               check_field("past_end", 32'(want.past_end), 32'(rsp_data.past_end));
            end
         end
      end
      samples_in_flight = lerp_expect_q.size();
   end

endmodule

/* dv/keyframe_track_lerp_unit_test.sv */
module keyframe_track_lerp_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import kfl_pkg::*;

   // Rough number of request transfers to issue before the run winds down.
   localparam int unsigned ITEM_TARGET   = 750;
   // Long enough for a sample with 64 keys, so this is a safe quiet period
   // before a key_count write and at the end of the run.
   localparam int unsigned SETTLE_CYCLES = 100;
   // The limit leaves several times the slowest legal run of roughly 750
   // transfers plus the settle periods.
   localparam int unsigned CYCLE_LIMIT   = 600000;

   typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_RARE} stall_mode_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   req_type                req_data    = '0;
   logic                   rsp_stall   = 1'b0;
   logic                   csr_wr_en   = 1'b0;
   logic [KEY_COUNT_W-1:0] csr_wr_data = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   rsp_type                rsp_data;

   int unsigned mismatch_count;
   int unsigned samples_in_flight;
   int unsigned load_count;
   int unsigned sample_count;
   int unsigned setting_count;
   int unsigned burst_left;
   int unsigned cycle_count;
   int unsigned stall_left;
   stall_mode_type stall_mode = STALL_NONE;

   // Key times as last issued, used only to aim sample times at the segments.
   logic [TIME_W-1:0] track_time [MAX_KEYS];

   keyframe_track_lerp_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   keyframe_track_lerp_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatch_count    (mismatch_count),
      .samples_in_flight (samples_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The response side stalls in modes that each last a random stretch: no
   // stalling at all, even odds, mostly stalled, and the occasional stall.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 256);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 7) != 0);
         default:     rsp_stall <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // Vector components lean towards the extremes and small values, where the
   // blend is most likely to go wrong, with plenty of fully random words too.
   function automatic logic [VAL_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type make_load(input int unsigned slot, input logic [TIME_W-1:0] t,
                                         input logic [VAL_W-1:0] x,
                                         input logic [VAL_W-1:0] y,
                                         input logic [VAL_W-1:0] z);
      req_type r;
      r.command  = CMD_LOAD;
      r.key_slot = SLOT_W'(slot);
      r.time_req = t;
      r.value_x  = x;
      r.value_y  = y;
      r.value_z  = z;
      return r;
   endfunction

   // The slot and vector fields of a sample are don't-cares, so they carry
   // random bits to show that the block really ignores them.
   function automatic req_type make_sample(input logic [TIME_W-1:0] t);
      req_type r;
      r.command  = CMD_SAMPLE;
      r.key_slot = SLOT_W'($urandom());
      r.time_req = t;
      r.value_x  = $urandom();
      r.value_y  = $urandom();
      r.value_z  = $urandom();
      return r;
   endfunction

   // Drives one request and returns at its transfer edge, or after the gap at a
   // burst's end. The sender works in bursts: within a burst valid stays high
   // from one transfer to the next, and at its end drops for a random gap.
   task automatic send_request(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.command == CMD_LOAD) begin
         track_time[item.key_slot] = item.time_req;
         load_count++;
      end else begin
         sample_count++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // key_count is only changed with the block idle: every sample has been
   // answered, and a quiet period lets any load still in hand complete.
   task automatic write_key_count(input logic [KEY_COUNT_W-1:0] setting);
      req_valid <= 1'b0;
      do @(negedge clock); while (samples_in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      setting_count++;
   endtask

   // One track: set key_count, load every key in use, then sample it. Most
   // tracks have rising key times, with repeated times now and then for
   // zero-length segments; one in ten is pure noise. The sampling is sprinkled
   // with loads that overwrite a key mid-stream.
   task automatic run_track_phase(input logic [KEY_COUNT_W-1:0] setting);
      int unsigned       n;
      int unsigned       seg;
      longint            stamp;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
      bit                noisy;
      n = (setting == 0) ? 1 : ((setting > MAX_KEYS) ? MAX_KEYS : setting);
      write_key_count(setting);
      noisy = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
         0:       stamp = 0;
         1:       stamp = $urandom_range(0, 32'h0000_FFFF);
         default: stamp = $urandom_range(0, 32'h4000_0000);
      endcase
      for (int unsigned k = 0; k < n; k++) begin
         t = noisy ? $urandom() : TIME_W'(stamp);
         send_request(make_load(k, t, random_value(), random_value(), random_value()));
         case ($urandom_range(0, 9))
            0:             stamp += 0;
            1:             stamp += $urandom_range(1, 255);
            2, 3, 4, 5, 6: stamp += $urandom_range(1, 32'h0004_0000);
            default:       stamp += $urandom_range(1, 32'h0800_0000);
         endcase
         if (stamp > 64'h0000_0000_FFFF_FFFF) stamp = 64'h0000_0000_FFFF_FFFF;
      end
      repeat ($urandom_range(6, 20)) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(make_load($urandom_range(0, n - 1), $urandom(), random_value(),
                                   random_value(), random_value()));
         end else begin
            seg = (n > 1) ? $urandom_range(0, n - 2) : 0;
            lo  = track_time[seg];
            hi  = track_time[(n > 1) ? seg + 1 : 0];
            if (lo > hi) begin
               t  = lo;
               lo = hi;
               hi = t;
            end
            case ($urandom_range(0, 9))
               0:       t = track_time[$urandom_range(0, n - 1)];
               1:       t = $urandom_range(0, track_time[0]);
               2:       t = track_time[n - 1] + $urandom_range(0, ~track_time[n - 1]);
               3:       t = $urandom();
               default: t = lo + $urandom_range(0, hi - lo);
            endcase
            send_request(make_sample(t));
         end
      end
   endtask

   initial begin : stimulus
      logic [KEY_COUNT_W-1:0] setting;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A key_count of zero behaves as a single key: key 0 comes back for any
      // time, never flagged as past the end. The top slot is loaded as well.
      write_key_count(7'd0);
      send_request(make_load(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
      send_request(make_load(63, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_sample(32'h0000_0000));
      send_request(make_sample(32'hFFFF_FFFF));

      // Four keys with full-scale swings between them and a zero-length
      // segment in the middle. Samples hit a time before key 0, a time exactly
      // on a key, the interior of both non-empty segments, the zero-length
      // segment, and the very end of the time range.
      write_key_count(7'd4);
      send_request(make_load(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
      send_request(make_load(1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000));
      send_request(make_load(2, 32'h0002_0000, 32'h0000_0000, 32'h1234_5678, 32'h8000_0000));
      send_request(make_load(3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hEDCB_A988, 32'h7FFF_FFFF));
      send_request(make_sample(32'h0000_0000));
      send_request(make_sample(32'h0001_0000));
      send_request(make_sample(32'h0001_8000));
      send_request(make_sample(32'h0001_FFFF));
      send_request(make_sample(32'h0002_0000));
      send_request(make_sample(32'h8000_0000));
      send_request(make_sample(32'hFFFF_FFFE));
      send_request(make_sample(32'hFFFF_FFFF));

      // Saturating count, a single key and a full track come first, then a mix
      // weighted towards short tracks.
      run_track_phase(7'd127);
      run_track_phase(7'd1);
      run_track_phase(7'd64);
      while (load_count + sample_count < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0:       setting = 7'd0;
            1:       setting = 7'd1;
            2:       setting = 7'd64;
            3:       setting = $urandom_range(65, 127);
            4, 5:    setting = $urandom_range(9, 63);
            default: setting = $urandom_range(2, 8);
         endcase
         run_track_phase(setting);
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (samples_in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d key loads and %0d track samples over %0d key_count settings,",
               load_count, sample_count, setting_count);
      $display("with bursty requests and patterned response stalls; %0d mismatches seen.",
               mismatch_count);
      if (mismatch_count == 0 && samples_in_flight == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
